@@ sv/tforf_pkg.sv @@
// Shared types, character codes and translation functions for the ORF finder.
package tforf_pkg;

    typedef logic [6:0] char_t;

    localparam char_t CH_A = 7'h41;
    localparam char_t CH_B = 7'h42;
    localparam char_t CH_C = 7'h43;
    localparam char_t CH_D = 7'h44;
    localparam char_t CH_E = 7'h45;
    localparam char_t CH_F = 7'h46;
    localparam char_t CH_G = 7'h47;
    localparam char_t CH_H = 7'h48;
    localparam char_t CH_I = 7'h49;
    localparam char_t CH_K = 7'h4B;
    localparam char_t CH_L = 7'h4C;
    localparam char_t CH_M = 7'h4D;
    localparam char_t CH_N = 7'h4E;
    localparam char_t CH_P = 7'h50;
    localparam char_t CH_Q = 7'h51;
    localparam char_t CH_R = 7'h52;
    localparam char_t CH_S = 7'h53;
    localparam char_t CH_T = 7'h54;
    localparam char_t CH_U = 7'h55;
    localparam char_t CH_V = 7'h56;
    localparam char_t CH_W = 7'h57;
    localparam char_t CH_X = 7'h58;
    localparam char_t CH_Y = 7'h59;
    localparam char_t CH_STOP = 7'h2A;
    localparam char_t CH_LO_A = 7'h61;
    localparam char_t CH_LO_Z = 7'h7A;

    localparam logic [2:0] REG_SEQ_LENGTH = 3'd0;
    localparam logic [2:0] REG_SCAN_START = 3'd1;
    localparam logic [2:0] REG_SCAN_END   = 3'd2;
    localparam logic [2:0] REG_REQ_START  = 3'd3;
    localparam logic [2:0] REG_COMPLEMENT = 3'd4;

    // upper case, then complement or U->T
    function automatic char_t norm_base(input char_t ch, input logic comp);
        char_t u;
        char_t r;
        u = ch;
        if (u >= CH_LO_A && u <= CH_LO_Z) u = u - 7'd32;
        r = u;
        if (!comp) begin
            if (u == CH_U) r = CH_T;
        end else begin
            case (u)
                CH_A: r = CH_T;
                CH_T: r = CH_A;
                CH_U: r = CH_A;
                CH_C: r = CH_G;
                CH_G: r = CH_C;
                CH_R: r = CH_Y;
                CH_Y: r = CH_R;
                CH_D: r = CH_H;
                CH_H: r = CH_D;
                CH_K: r = CH_M;
                CH_M: r = CH_K;
                CH_B: r = CH_V;
                CH_V: r = CH_B;
                default: r = u;
            endcase
        end
        return r;
    endfunction

    function automatic logic is_pyr(input char_t c);
        return c == CH_T || c == CH_C || c == CH_Y;
    endfunction

    function automatic logic is_pur(input char_t c);
        return c == CH_A || c == CH_G || c == CH_R;
    endfunction

    function automatic char_t two_way(input char_t c, input char_t py, input char_t pu);
        char_t r;
        r = CH_X;
        if (is_pyr(c)) r = py;
        else if (is_pur(c)) r = pu;
        return r;
    endfunction

    // standard code with Y/R/H third-position ambiguity
    function automatic char_t translate(input char_t a, input char_t b, input char_t c);
        char_t r;
        r = CH_X;
        if (b == CH_T) begin
            if (a == CH_T) r = two_way(c, CH_F, CH_L);
            else if (a == CH_C) r = CH_L;
            else if (a == CH_A) begin
                if (c == CH_G) r = CH_M;
                else if (c == CH_T || c == CH_A || c == CH_C || c == CH_H) r = CH_I;
            end else if (a == CH_G) r = CH_V;
        end else if (b == CH_C) begin
            if (a == CH_T) r = CH_S;
            else if (a == CH_C) r = CH_P;
            else if (a == CH_A) r = CH_T;
            else if (a == CH_G) r = CH_A;
        end else if (b == CH_A) begin
            if (a == CH_T) r = two_way(c, CH_Y, CH_STOP);
            else if (a == CH_C) r = two_way(c, CH_H, CH_Q);
            else if (a == CH_A) r = two_way(c, CH_N, CH_K);
            else if (a == CH_G) r = two_way(c, CH_D, CH_E);
        end else if (b == CH_G) begin
            if (a == CH_T) begin
                if (is_pyr(c)) r = CH_C;
                else if (c == CH_A) r = CH_STOP;
                else if (c == CH_G) r = CH_W;
            end else if (a == CH_C) r = CH_R;
            else if (a == CH_A) r = two_way(c, CH_S, CH_R);
            else if (a == CH_G) r = CH_G;
        end
        return r;
    endfunction

    function automatic logic [1:0] red3(input logic [2:0] v);
        logic [2:0] r;
        r = v;
        if (r >= 3'd6) r = r - 3'd6;
        else if (r >= 3'd3) r = r - 3'd3;
        return r[1:0];
    endfunction

    // 17-bit value mod 3: base-4 digits each count 1 mod 3
    function automatic logic [1:0] mod3_17(input logic [16:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = 5'(v[16]);
        for (int i = 0; i < 8; i++) s = s + 5'(v[2*i +: 2]);
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        return red3(t);
    endfunction

    // frame label (L + 5 - p) mod 3 from residues
    function automatic logic [1:0] frame_of(input logic [1:0] lm, input logic [1:0] pm);
        return red3(3'(lm) + 3'd2 + 3'(2'd3 - pm));
    endfunction

endpackage

@@ sv/three_frame_orf_finder.sv @@
// Three-frame ORF finder: input register, tracker update, result register.
// m_tvalid is registered as the last item advances out of the input register.
// Throughput: one nucleotide per cycle; the input register keeps taking items
//   while a result waits, and stalls only when a last item meets a held result.
// Reset (aresetn low, synchronous): registers zero, trackers cleared, Met
//   trackers waiting for M, lookahead bases X. The stream state is also
//   cleared after every last item; configuration registers keep their values.
module three_frame_orf_finder
    import tforf_pkg::*;
#(
    parameter int MAX_LEN = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [6:0] nucleotide, [7] zero
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // best_frame, run_start, run_end, run_codons,
                                   // ends_with_stop, then zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int PW = $clog2(MAX_LEN + 3);
    localparam int CW = (PW > 17) ? PW : 17;
    localparam logic [PW-1:0] POS_SAT = PW'(MAX_LEN + 2);
    localparam logic [CW-1:0] POS_LIM = CW'(MAX_LEN);

    // configuration
    logic [16:0] seq_length_reg;
    logic [1:0]  seq_mod3_reg;
    logic [15:0] scan_start_reg;
    logic [16:0] scan_end_reg;
    logic        req_start_reg;
    logic        comp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_length_reg <= '0;
            seq_mod3_reg   <= '0;
            scan_start_reg <= '0;
            scan_end_reg   <= '0;
            req_start_reg  <= 1'b0;
            comp_reg       <= 1'b0;
        end else begin
            seq_mod3_reg <= mod3_17(seq_length_reg);
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SEQ_LENGTH: seq_length_reg <= cfg_data;
                    REG_SCAN_START: scan_start_reg <= cfg_data[15:0];
                    REG_SCAN_END:   scan_end_reg   <= cfg_data;
                    REG_REQ_START:  req_start_reg  <= cfg_data[0];
                    REG_COMPLEMENT: comp_reg       <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // input register
    logic  in_valid_reg;
    char_t in_base_reg;
    logic  in_last_reg;
    logic  advance;
    logic  m_valid_reg;
    logic [55:0] m_data_reg;

    assign advance  = in_valid_reg && !(in_last_reg && m_valid_reg && !m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_base_reg <= norm_base(s_tdata[6:0], comp_reg);
            in_last_reg <= s_tlast;
        end
    end

    // stream state
    char_t        la0_reg, la1_reg;
    logic [PW-1:0] pos_cnt_reg;
    logic [1:0]   pos_mod3_reg;
    logic         await_reg  [6];
    logic [16:0]  cur_len_reg[6];
    logic [15:0]  cur_beg_reg[6];
    logic [16:0]  best_len_reg[6];
    logic [15:0]  best_beg_reg[6];
    logic [15:0]  best_fin_reg[6];
    logic         best_stop_reg[6];

    logic         await_next  [6];
    logic [16:0]  cur_len_next[6];
    logic [15:0]  cur_beg_next[6];
    logic [16:0]  best_len_next[6];
    logic [15:0]  best_beg_next[6];
    logic [15:0]  best_fin_next[6];
    logic         best_stop_next[6];
    logic [55:0]  result_next;

    function automatic logic in_window(input logic [PW-1:0] p, input logic [15:0] s,
                                       input logic [16:0] e);
        return CW'(p) < POS_LIM && CW'(p) >= CW'(s) && CW'(p) < CW'(e);
    endfunction

    always_comb begin
        logic [PW-1:0] pos_a, pos_b;
        char_t         aa_a, aa_b;
        logic          hit_a, hit_b;
        logic [1:0]    fr_a, fr_b;
        logic          hit_f;
        char_t         aa_f;
        logic [15:0]   pos_f;
        logic [16:0]   inc;
        logic [2:0]    base;
        logic [16:0]   len;
        logic          stop;
        logic [1:0]    sel;
        logic [2:0]    ti;

        // middle codon at k-2, tail codon at k-1 (the codon at k is always X)
        pos_a = pos_cnt_reg - PW'(2);
        pos_b = pos_cnt_reg - PW'(1);
        aa_a  = translate(la0_reg, la1_reg, in_base_reg);
        aa_b  = translate(la1_reg, in_base_reg, CH_X);
        hit_a = pos_cnt_reg >= PW'(2) && in_window(pos_a, scan_start_reg, scan_end_reg);
        hit_b = in_last_reg && pos_cnt_reg >= PW'(1) && aa_b != CH_X &&
                in_window(pos_b, scan_start_reg, scan_end_reg);
        fr_a  = frame_of(seq_mod3_reg, red3(3'(pos_mod3_reg) + 3'd1));
        fr_b  = frame_of(seq_mod3_reg, red3(3'(pos_mod3_reg) + 3'd2));

        for (int t = 0; t < 6; t++) begin
            await_next[t]     = await_reg[t];
            cur_len_next[t]   = cur_len_reg[t];
            cur_beg_next[t]   = cur_beg_reg[t];
            best_len_next[t]  = best_len_reg[t];
            best_beg_next[t]  = best_beg_reg[t];
            best_fin_next[t]  = best_fin_reg[t];
            best_stop_next[t] = best_stop_reg[t];

            // the two scanned positions always fall in different frames
            if (hit_a && 2'(t % 3) == fr_a) begin
                hit_f = 1'b1; aa_f = aa_a; pos_f = pos_a[15:0];
            end else begin
                hit_f = hit_b && 2'(t % 3) == fr_b; aa_f = aa_b; pos_f = pos_b[15:0];
            end
            inc = cur_len_reg[t] + 17'd1;

            if (hit_f) begin
                if (await_reg[t]) begin
                    if (aa_f == CH_M) begin
                        cur_len_next[t] = 17'd1;
                        cur_beg_next[t] = pos_f;
                        await_next[t]   = 1'b0;
                    end
                end else begin
                    cur_len_next[t] = inc;
                    if (aa_f == CH_STOP) begin
                        await_next[t] = 1'b1;
                        if (inc > best_len_reg[t]) begin
                            best_len_next[t]  = inc;
                            best_beg_next[t]  = cur_beg_reg[t];
                            best_fin_next[t]  = pos_f;
                            best_stop_next[t] = 1'b1;
                        end
                    end
                end
            end

            // open run at sequence end closes at scan_end-1
            if (in_last_reg && cur_len_next[t] > best_len_next[t]) begin
                best_len_next[t]  = cur_len_next[t];
                best_beg_next[t]  = cur_beg_next[t];
                best_fin_next[t]  = scan_end_reg[15:0] - 16'd1;
                best_stop_next[t] = 1'b0;
            end
        end

        // Met answer if requested and present, else free mode
        base = 3'd3;
        if (req_start_reg &&
            (best_len_next[0] | best_len_next[1] | best_len_next[2]) != 17'd0)
            base = 3'd0;
        len  = best_len_next[base];
        stop = best_stop_next[base];
        if (best_len_next[base + 3'd1] > len) begin
            len  = best_len_next[base + 3'd1];
            stop = best_stop_next[base + 3'd1];
        end
        if (best_len_next[base + 3'd2] > len) begin
            len  = best_len_next[base + 3'd2];
            stop = best_stop_next[base + 3'd2];
        end
        if (best_len_next[base + 3'd2] == len) sel = 2'd2;
        else if (best_len_next[base + 3'd1] == len) sel = 2'd1;
        else sel = 2'd0;
        ti = base + 3'(sel);
        result_next = {4'd0, stop, len, best_fin_next[ti], best_beg_next[ti], sel};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_last_reg)) begin
            la0_reg      <= CH_X;
            la1_reg      <= CH_X;
            pos_cnt_reg  <= '0;
            pos_mod3_reg <= '0;
            for (int t = 0; t < 6; t++) begin
                await_reg[t]     <= (t < 3);
                cur_len_reg[t]   <= '0;
                cur_beg_reg[t]   <= '0;
                best_len_reg[t]  <= '0;
                best_beg_reg[t]  <= '0;
                best_fin_reg[t]  <= '0;
                best_stop_reg[t] <= 1'b0;
            end
        end else if (advance) begin
            la0_reg <= la1_reg;
            la1_reg <= in_base_reg;
            if (pos_cnt_reg < POS_SAT) begin
                pos_cnt_reg  <= pos_cnt_reg + PW'(1);
                pos_mod3_reg <= red3(3'(pos_mod3_reg) + 3'd1);
            end
            for (int t = 0; t < 6; t++) begin
                await_reg[t]     <= await_next[t];
                cur_len_reg[t]   <= cur_len_next[t];
                cur_beg_reg[t]   <= cur_beg_next[t];
                best_len_reg[t]  <= best_len_next[t];
                best_beg_reg[t]  <= best_beg_next[t];
                best_fin_reg[t]  <= best_fin_next[t];
                best_stop_reg[t] <= best_stop_next[t];
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) m_data_reg <= result_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
